[rtl/core/utfd_pkg.sv]
// Shared types, constants and helpers for the UTF-8 byte stream decoder.
// No dependencies; imported by utfd_out_queue and utf8_byte_stream_decoder.

package utfd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int LEN_W  = 3;

    localparam logic [BYTE_W-1:0] C_LEAD_MIN     = 8'hC0;
    localparam logic [BYTE_W-1:0] C_TAG_MASK     = 8'hC0;
    localparam logic [BYTE_W-1:0] C_CONT_TAG     = 8'h80;
    localparam logic [5:0]        C_PAYLOAD_MASK = 6'h3F;
    localparam logic [CP_W-1:0]   C_MAX_CP_RESET = 21'h10FFFF;
    localparam logic [LEN_W-1:0]  C_SINGLE_LEN   = 3'd1;

    // Load request from the decode logic to the result queue
    typedef struct packed {
        logic             load;
        logic             dec;    // one decoded code point rather than raw bytes
        logic [LEN_W-1:0] len;
        logic [CP_W-1:0]  cp;
    } t_q_ctrl;

    // Sequence length called for by a lead byte: 2 plus the run of ones from bit 5 down.
    // 0xFE gives 7, 0xFF gives 8.
    function automatic logic [3:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [3:0] n;
        logic       run;
        n   = 4'd2;
        run = 1'b1;
        for (int i = 5; i >= 0; i--) begin
            if (run && b[i]) begin
                n = n + 4'd1;
            end else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

endpackage

[rtl/core/utfd_out_queue.sv]
// Result queue: holds the results of one input byte and hands them out one per transfer.
// Depends on utfd_pkg.

module utfd_out_queue #(
    parameter int MAX_SEQ_LEN = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  utfd_pkg::t_q_ctrl             i_ctrl,
    input  logic [$clog2(MAX_SEQ_LEN+1)-1:0] i_cnt,
    input  logic [utfd_pkg::BYTE_W-1:0]   i_bytes [MAX_SEQ_LEN],
    output logic                          o_can_load,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [utfd_pkg::CP_W-1:0]     o_code_point,
    output logic [utfd_pkg::LEN_W-1:0]    o_byte_count,
    output logic                          o_last_of_run
);
    import utfd_pkg::*;

    localparam int QCW = $clog2(MAX_SEQ_LEN + 1);

    logic [BYTE_W-1:0] r_bytes [MAX_SEQ_LEN];
    logic [QCW-1:0]    r_rem;
    logic              r_dec;
    logic [LEN_W-1:0]  r_len;
    logic [CP_W-1:0]   r_cp;
    logic              out_xfer;

    assign out_xfer    = o_out_valid && i_out_ready;
    assign o_out_valid = (r_rem != '0);
    assign o_can_load  = (r_rem == '0) || ((r_rem == QCW'(1)) && i_out_ready);

    assign o_code_point  = r_dec ? r_cp : {{(CP_W-BYTE_W){1'b0}}, r_bytes[0]};
    assign o_byte_count  = r_dec ? r_len : C_SINGLE_LEN;
    assign o_last_of_run = (r_rem == QCW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_dec <= 1'b0;
        end else if (i_ctrl.load) begin
            r_rem <= i_cnt;
            r_dec <= i_ctrl.dec;
        end else if (out_xfer) begin
            r_rem <= r_rem - QCW'(1);
        end
    end

    // Payload: load in parallel, shift down on each transfer
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_bytes <= i_bytes;
            r_len   <= i_ctrl.len;
            r_cp    <= i_ctrl.cp;
        end else if (out_xfer) begin
            for (int i = 0; i < MAX_SEQ_LEN - 1; i++) begin
                r_bytes[i] <= r_bytes[i+1];
            end
        end
    end

    a_dec_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dec && r_rem != '0) |-> (r_rem == QCW'(1)))
        else $error("decoded result queued with more than one entry");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= QCW'(MAX_SEQ_LEN))
        else $error("queue count beyond sequence limit");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.load && r_rem > QCW'(1)) |-> 1'b0)
        else $error("load while earlier results still pending");

endmodule

[rtl/core/utf8_byte_stream_decoder.sv]
// UTF-8 byte stream decoder, top level: sequence tracking and fallback decisions.
// Depends on utfd_pkg and utfd_out_queue.
//
//   channel  direction  handshake                    payload
//   input    in         i_in_valid / o_in_ready      i_data_byte, i_end_of_line
//   result   out        o_out_valid / i_out_ready    o_code_point, o_byte_count, o_last_of_run
//   config   in         i_cfg_wr_en                  i_cfg_wr_data (max_code_point)
//
// A byte is decoded in the cycle it is taken; its results appear the next cycle.
// One byte per cycle while each byte gives at most one result and the result side keeps
// up; a byte that gives more than one result holds the input while the result queue drains.
// Reset (synchronous, active low) empties the queue, drops any open sequence and
// sets max_code_point to 0x10FFFF. No clearing pass.
// A stalled result side stops the input as soon as the queue holds any entry.

module utf8_byte_stream_decoder #(
    parameter int MAX_SEQ_LEN = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [utfd_pkg::CP_W-1:0]     i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [utfd_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_end_of_line,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [utfd_pkg::CP_W-1:0]     o_code_point,
    output logic [utfd_pkg::LEN_W-1:0]    o_byte_count,
    output logic                          o_last_of_run
);
    import utfd_pkg::*;

    localparam int HCW  = $clog2(MAX_SEQ_LEN);
    localparam int QCW  = $clog2(MAX_SEQ_LEN + 1);
    localparam int PW   = 5 * MAX_SEQ_LEN + 1;   // payload bits of the longest sequence
    localparam int CMPW = (PW > CP_W) ? PW : CP_W;
    localparam int LW   = 4;

    logic [CP_W-1:0]   r_max_cp;
    logic [BYTE_W-1:0] r_held [MAX_SEQ_LEN-1];
    logic [HCW-1:0]    r_held_cnt;
    logic [LEN_W-1:0]  r_exp_len;
    logic [PW-1:0]     r_partial;

    logic [BYTE_W-1:0] n_held [MAX_SEQ_LEN-1];
    logic [HCW-1:0]    n_held_cnt;
    logic [LEN_W-1:0]  n_exp_len;
    logic [PW-1:0]     n_partial;

    logic              in_xfer;
    logic              can_load;
    t_q_ctrl           q_ctrl;
    logic [QCW-1:0]    q_cnt;
    logic [BYTE_W-1:0] q_bytes [MAX_SEQ_LEN];

    logic              is_cont;
    logic [3:0]        lead_n;
    logic              opens;
    logic [PW-1:0]     ext_partial;
    logic [QCW-1:0]    held_q;
    logic [QCW-1:0]    grown_cnt;
    logic              complete;
    logic              too_big;
    logic [CMPW-1:0]   ext_wide;

    assign o_in_ready = can_load;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign is_cont     = ((i_data_byte & C_TAG_MASK) == C_CONT_TAG);
    assign lead_n      = lead_len(i_data_byte);
    assign opens       = (i_data_byte >= C_LEAD_MIN) && (lead_n <= LW'(MAX_SEQ_LEN))
                         && !i_end_of_line;
    assign ext_partial = {r_partial[PW-7:0], i_data_byte[5:0] & C_PAYLOAD_MASK};
    assign held_q      = QCW'(r_held_cnt);
    assign grown_cnt   = held_q + QCW'(1);
    assign complete    = (LW'(grown_cnt) >= LW'(r_exp_len));
    assign too_big     = (CMPW'(ext_partial) > CMPW'(r_max_cp));
    assign ext_wide    = CMPW'(ext_partial);

    // Queue image: held bytes in order, the current byte after them
    always_comb begin
        for (int i = 0; i < MAX_SEQ_LEN - 1; i++) begin
            q_bytes[i] = (HCW'(i) < r_held_cnt) ? r_held[i] : i_data_byte;
        end
        q_bytes[MAX_SEQ_LEN-1] = i_data_byte;
    end

    always_comb begin
        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        n_exp_len  = r_exp_len;
        n_partial  = r_partial;
        q_cnt      = '0;
        q_ctrl     = '0;
        q_ctrl.load = in_xfer;
        q_ctrl.len  = r_exp_len;
        q_ctrl.cp   = ext_wide[CP_W-1:0];

        if (r_held_cnt == '0 || !is_cont) begin
            // flush whatever is held, then take the byte afresh
            q_cnt = held_q + (opens ? QCW'(0) : QCW'(1));
            if (opens) begin
                n_held[0]  = i_data_byte;
                n_held_cnt = HCW'(1);
                n_exp_len  = lead_n[LEN_W-1:0];
                n_partial  = {{(PW-BYTE_W){1'b0}}, i_data_byte & (8'hFF >> (lead_n + 4'd1))};
            end else begin
                n_held_cnt = '0;
                n_exp_len  = '0;
                n_partial  = '0;
            end
        end else if (complete || i_end_of_line) begin
            if (complete && !too_big) begin
                q_cnt      = QCW'(1);
                q_ctrl.dec = 1'b1;
            end else begin
                q_cnt = grown_cnt;
            end
            n_held_cnt = '0;
            n_exp_len  = '0;
            n_partial  = '0;
        end else begin
            for (int i = 0; i < MAX_SEQ_LEN - 1; i++) begin
                if (HCW'(i) == r_held_cnt) begin
                    n_held[i] = i_data_byte;
                end
            end
            n_held_cnt = grown_cnt[HCW-1:0];
            n_partial  = ext_partial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cp   <= C_MAX_CP_RESET;
            r_held_cnt <= '0;
            r_exp_len  <= '0;
            r_partial  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_cp <= i_cfg_wr_data;
            end
            if (in_xfer) begin
                r_held_cnt <= n_held_cnt;
                r_exp_len  <= n_exp_len;
                r_partial  <= n_partial;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_held <= n_held;
        end
    end

    utfd_out_queue #(
        .MAX_SEQ_LEN (MAX_SEQ_LEN)
    ) u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (q_ctrl),
        .i_cnt         (q_cnt),
        .i_bytes       (q_bytes),
        .o_can_load    (can_load),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_code_point  (o_code_point),
        .o_byte_count  (o_byte_count),
        .o_last_of_run (o_last_of_run)
    );

    a_open_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_cnt != '0) |-> (LW'(r_held_cnt) < LW'(r_exp_len)))
        else $error("open sequence already holds its full length");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_cnt == '0) |-> (r_exp_len == '0))
        else $error("expected length left over with no sequence open");

    a_multi_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_count != C_SINGLE_LEN) |-> o_last_of_run)
        else $error("decoded result not marked last of run");

endmodule
